FILE: rtl/core/brle_pkg.sv
// Shared types, constants and a lookup function for the byte run-length encoder.
`default_nettype none
package brle_pkg;

    localparam int CFG_IDX_W      = 3;
    localparam int CFG_DATA_W     = 64;
    localparam int QUEUE_DEPTH    = 4;
    localparam int BYTE_W         = 8;
    localparam int COUNT_W        = 5;
    localparam int NUM_SLICES     = 4;
    localparam int TABLE_W        = NUM_SLICES * CFG_DATA_W;

    localparam logic [COUNT_W-1:0] MAX_EXTRA = COUNT_W'(31);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ELIG_MASK_0  = 3'd0,
        CFG_ELIG_MASK_1  = 3'd1,
        CFG_ELIG_MASK_2  = 3'd2,
        CFG_ELIG_MASK_3  = 3'd3,
        CFG_COUNT_CODE_0 = 3'd4,
        CFG_COUNT_CODE_1 = 3'd5,
        CFG_COUNT_CODE_2 = 3'd6,
        CFG_COUNT_CODE_3 = 3'd7
    } t_cfg_idx;

    typedef struct packed {
        logic               has_close;
        logic [COUNT_W-1:0] close_count;
        logic               has_lit;
        logic [BYTE_W-1:0]  lit_byte;
        logic               has_zero;
        logic               eob;
    } t_op;

    function automatic logic [BYTE_W-1:0] code_for(
        input logic [TABLE_W-1:0] codes,
        input logic [COUNT_W-1:0] count
    );
        return codes[{count, 3'b000} +: BYTE_W];
    endfunction

endpackage
`default_nettype wire

FILE: rtl/core/byte_run_length_encoder_top.sv
// Top level of the streaming byte run-length encoder.
// Input channel: drive i_data_byte and i_end_of_block with push high; a word
// is taken at a clock edge where push is high and full is low.
// Output channel: while empty is low, o_out_byte, o_last_of_item and
// o_block_done show the oldest result; pop high takes it.
// Configuration: i_cfg_we writes i_cfg_data into register i_cfg_idx
// (0..3 eligible masks, 4..7 count code tables) at once; write only when idle.
// Path: a word's results pass the op queue, work register and output register.
// Throughput: the back end emits one result word per cycle while the output
// register is empty or popped; a word makes one, two or three results,
// emitted in turn, and bytes absorbed into a run make no result. The op
// queue lets the front run ahead by up to QUEUE_DEPTH ops.
// Reset: synchronous, active low; clears run state, queue pointers, work and
// output valid flags and all configuration registers to zero.
// Stall: with pop low, the output word holds, the back end stops, the queue
// fills and full rises, after which no input word is taken.
`default_nettype none
module byte_run_length_encoder_top #(
    parameter int QUEUE_DEPTH = brle_pkg::QUEUE_DEPTH
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_cfg_we,
    input  wire logic [brle_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  wire logic [brle_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  wire logic                              push,
    output logic                                   full,
    input  wire logic [brle_pkg::BYTE_W-1:0]       i_data_byte,
    input  wire logic                              i_end_of_block,
    output logic                                   empty,
    input  wire logic                              pop,
    output logic [brle_pkg::BYTE_W-1:0]            o_out_byte,
    output logic                                   o_last_of_item,
    output logic                                   o_block_done
);

    logic          accept;
    logic          op_valid;
    brle_pkg::t_op front_op;
    logic          q_empty;
    logic          q_rd;
    brle_pkg::t_op q_op;

    assign accept = push && !full;

    brle_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_accept       (accept),
        .i_data_byte    (i_data_byte),
        .i_end_of_block (i_end_of_block),
        .o_op_valid     (op_valid),
        .o_op           (front_op)
    );

    brle_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (accept && op_valid),
        .i_op    (front_op),
        .i_rd    (q_rd),
        .o_full  (full),
        .o_empty (q_empty),
        .o_op    (q_op)
    );

    brle_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_q_empty      (q_empty),
        .i_q_op         (q_op),
        .o_q_rd         (q_rd),
        .o_empty        (empty),
        .i_pop          (pop),
        .o_out_byte     (o_out_byte),
        .o_last_of_item (o_last_of_item),
        .o_block_done   (o_block_done)
    );

endmodule
`default_nettype wire

FILE: rtl/core/brle_front.sv
// Front end: tracks run state, turns each input word into an output op or absorbs it into the open run.
`default_nettype none
module brle_front (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_cfg_we,
    input  wire logic [brle_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  wire logic [brle_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  wire logic                              i_accept,
    input  wire logic [brle_pkg::BYTE_W-1:0]       i_data_byte,
    input  wire logic                              i_end_of_block,
    output logic                                   o_op_valid,
    output brle_pkg::t_op                          o_op
);

    logic [brle_pkg::TABLE_W-1:0] r_mask;
    logic                         r_run_open;
    logic [brle_pkg::BYTE_W-1:0]  r_run_symbol;
    logic [brle_pkg::COUNT_W-1:0] r_run_extra;

    logic                         n_run_open;
    logic [brle_pkg::BYTE_W-1:0]  n_run_symbol;
    logic [brle_pkg::COUNT_W-1:0] n_run_extra;

    logic                         eligible;
    logic                         same;
    logic [brle_pkg::COUNT_W-1:0] extra_inc;

    assign eligible  = r_mask[i_data_byte];
    assign same      = r_run_open && !i_end_of_block && (i_data_byte == r_run_symbol);
    assign extra_inc = r_run_extra + brle_pkg::COUNT_W'(1);

    always_comb begin
        o_op         = '0;
        o_op_valid   = 1'b0;
        n_run_open   = r_run_open;
        n_run_symbol = r_run_symbol;
        n_run_extra  = r_run_extra;
        if (same) begin
            if (extra_inc == brle_pkg::MAX_EXTRA) begin
                o_op_valid       = 1'b1;
                o_op.has_close   = 1'b1;
                o_op.close_count = brle_pkg::MAX_EXTRA;
                n_run_open       = 1'b0;
                n_run_extra      = '0;
            end else begin
                n_run_extra = extra_inc;
            end
        end else begin
            o_op_valid       = 1'b1;
            o_op.has_close   = r_run_open;
            o_op.close_count = r_run_extra;
            o_op.has_lit     = 1'b1;
            o_op.lit_byte    = i_data_byte;
            o_op.has_zero    = eligible && i_end_of_block;
            o_op.eob         = i_end_of_block;
            n_run_open       = eligible && !i_end_of_block;
            n_run_symbol     = i_data_byte;
            n_run_extra      = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask       <= '0;
            r_run_open   <= 1'b0;
            r_run_symbol <= '0;
            r_run_extra  <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    brle_pkg::CFG_ELIG_MASK_0: r_mask[0*brle_pkg::CFG_DATA_W +: brle_pkg::CFG_DATA_W] <= i_cfg_data;
                    brle_pkg::CFG_ELIG_MASK_1: r_mask[1*brle_pkg::CFG_DATA_W +: brle_pkg::CFG_DATA_W] <= i_cfg_data;
                    brle_pkg::CFG_ELIG_MASK_2: r_mask[2*brle_pkg::CFG_DATA_W +: brle_pkg::CFG_DATA_W] <= i_cfg_data;
                    brle_pkg::CFG_ELIG_MASK_3: r_mask[3*brle_pkg::CFG_DATA_W +: brle_pkg::CFG_DATA_W] <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_accept) begin
                r_run_open   <= n_run_open;
                r_run_symbol <= n_run_symbol;
                r_run_extra  <= n_run_extra;
            end
        end
    end

endmodule
`default_nettype wire

FILE: rtl/core/brle_queue.sv
// Short op queue between the front end and the back end.
`default_nettype none
module brle_queue #(
    parameter int DEPTH = brle_pkg::QUEUE_DEPTH
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_wr,
    input  wire brle_pkg::t_op i_op,
    input  wire logic          i_rd,
    output logic               o_full,
    output logic               o_empty,
    output brle_pkg::t_op      o_op
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    brle_pkg::t_op    r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    logic do_wr;
    logic do_rd;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_op    = r_mem[r_rd_ptr];
    assign do_wr   = i_wr && !o_full;
    assign do_rd   = i_rd && !o_empty;

    always_ff @(posedge i_clk) begin
        if (do_wr) begin
            r_mem[r_wr_ptr] <= i_op;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_wr) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
            end
            if (do_rd) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
            end
            if (do_wr && !do_rd) begin
                r_count <= r_count + CNT_W'(1);
            end else if (do_rd && !do_wr) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

endmodule
`default_nettype wire

FILE: rtl/core/brle_back.sv
// Back end: expands each op into code and literal words behind an output register.
`default_nettype none
module brle_back (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_cfg_we,
    input  wire logic [brle_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  wire logic [brle_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  wire logic                              i_q_empty,
    input  wire brle_pkg::t_op                     i_q_op,
    output logic                                   o_q_rd,
    output logic                                   o_empty,
    input  wire logic                              i_pop,
    output logic [brle_pkg::BYTE_W-1:0]            o_out_byte,
    output logic                                   o_last_of_item,
    output logic                                   o_block_done
);

    logic [brle_pkg::TABLE_W-1:0] r_codes;
    logic                         r_work_valid;
    brle_pkg::t_op                r_work;
    logic                         r_out_valid;
    logic [brle_pkg::BYTE_W-1:0]  r_out_byte;
    logic                         r_out_last;
    logic                         r_out_done;

    brle_pkg::t_op                n_work;
    logic [brle_pkg::BYTE_W-1:0]  n_out_byte;
    logic                         n_out_last;

    logic out_free;
    logic emit;
    logic work_fin;

    assign out_free = !r_out_valid || i_pop;
    assign emit     = r_work_valid && out_free;
    assign work_fin = emit && n_out_last;
    assign o_q_rd   = (!r_work_valid || work_fin) && !i_q_empty;

    always_comb begin
        n_work = r_work;
        if (r_work.has_close) begin
            n_out_byte       = brle_pkg::code_for(r_codes, r_work.close_count);
            n_work.has_close = 1'b0;
            n_out_last       = !r_work.has_lit && !r_work.has_zero;
        end else if (r_work.has_lit) begin
            n_out_byte     = r_work.lit_byte;
            n_work.has_lit = 1'b0;
            n_out_last     = !r_work.has_zero;
        end else begin
            n_out_byte      = brle_pkg::code_for(r_codes, '0);
            n_work.has_zero = 1'b0;
            n_out_last      = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_rd) begin
            r_work <= i_q_op;
        end else if (emit) begin
            r_work <= n_work;
        end
        if (emit) begin
            r_out_byte <= n_out_byte;
            r_out_last <= n_out_last;
            r_out_done <= n_out_last && r_work.eob;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_codes      <= '0;
            r_work_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    brle_pkg::CFG_COUNT_CODE_0: r_codes[0*brle_pkg::CFG_DATA_W +: brle_pkg::CFG_DATA_W] <= i_cfg_data;
                    brle_pkg::CFG_COUNT_CODE_1: r_codes[1*brle_pkg::CFG_DATA_W +: brle_pkg::CFG_DATA_W] <= i_cfg_data;
                    brle_pkg::CFG_COUNT_CODE_2: r_codes[2*brle_pkg::CFG_DATA_W +: brle_pkg::CFG_DATA_W] <= i_cfg_data;
                    brle_pkg::CFG_COUNT_CODE_3: r_codes[3*brle_pkg::CFG_DATA_W +: brle_pkg::CFG_DATA_W] <= i_cfg_data;
                    default: ;
                endcase
            end
            if (o_q_rd) begin
                r_work_valid <= 1'b1;
            end else if (work_fin) begin
                r_work_valid <= 1'b0;
            end
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_empty        = !r_out_valid;
    assign o_out_byte     = r_out_byte;
    assign o_last_of_item = r_out_last;
    assign o_block_done   = r_out_done;

endmodule
`default_nettype wire
